// ----- hw/rtl/gcd_pkg.sv -----
// Shared types, constants and table functions for the great-circle distance core.
`timescale 1ns / 1ps

package gcd_pkg;

    localparam int CORDIC_STAGES_DEF = 24;

    localparam int LAT_W  = 28;
    localparam int LON_W  = 29;
    localparam int DEG_W  = 29;
    localparam int DIFF_W = 30;
    localparam int ANG_W  = 36;
    localparam int XY_W   = 34;
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;
    localparam int DIST_W = 25;
    localparam int PP_W   = 48;
    localparam int SUM_W  = 66;

    localparam int ROT_LANES   = 4;
    localparam int LANE_DLAT   = 0;
    localparam int LANE_DLON   = 1;
    localparam int LANE_LAT1   = 2;
    localparam int LANE_LAT2   = 3;
    localparam int ISQRT_LANES = 2;
    localparam int ISQRT_STEPS = 32;
    localparam int LANE_A      = 0;
    localparam int LANE_B      = 1;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 32;

    typedef logic signed [LAT_W-1:0]  lat_t;
    typedef logic signed [LON_W-1:0]  lon_t;
    typedef logic signed [DEG_W-1:0]  deg_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [ANG_W-1:0]  angle_t;
    typedef logic signed [XY_W-1:0]   xy_t;
    typedef logic signed [PP_W-1:0]   pp_t;
    typedef logic [RAD_W-1:0]         rad_t;
    typedef logic [ROOT_W-1:0]        root_t;
    typedef logic [DIST_W-1:0]        dist_t;

    localparam lat_t  LAT_LIMIT = 28'sd94371840;
    localparam diff_t HALF_TURN = 30'sd188743680;
    localparam diff_t FULL_TURN = 30'sd377487360;

    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] D2R_Q40 = ((PI_Q60 / 64'd180) + 64'd524288) >> 20;
    localparam int K_LO_W = 18;
    localparam int K_HI_W = 17;
    localparam logic [K_LO_W-1:0] D2R_LO = D2R_Q40[K_LO_W-1:0];
    localparam logic [K_HI_W-1:0] D2R_HI = D2R_Q40[K_LO_W+K_HI_W-1:K_LO_W];

    localparam logic [63:0] ONE_Q60      = 64'd1 << 60;
    localparam logic [23:0] EARTH_DIAM_M = 24'd12742000;
    localparam dist_t       DIST_MAX     = 25'd20015087;

    function automatic logic [63:0] long_div(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] val;
        logic [63:0] r;
        logic [63:0] bit_v;
        val   = v;
        r     = '0;
        bit_v = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (val >= r + bit_v) begin
                val = val - (r + bit_v);
                r   = (r >> 1) + bit_v;
            end else begin
                r = r >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return r;
    endfunction

    // Arctangent of 2^-i in Q32 from a truncated Taylor series in Q60.
    function automatic angle_t atan_q32(int i);
        logic [63:0] acc;
        logic [63:0] term;
        int n;
        acc = '0;
        if (i == 0) begin
            acc = PI_Q60 >> 2;
        end else begin
            for (int k = 0; k < 31; k++) begin
                n = i * (2 * k + 1);
                if (n <= 60) begin
                    term = long_div(64'd1 << (60 - n), 64'(2 * k + 1));
                    if ((k & 1) != 0) begin
                        acc = acc - term;
                    end else begin
                        acc = acc + term;
                    end
                end
            end
        end
        return angle_t'((acc + (64'd1 << 27)) >> 28);
    endfunction

    // Inverse CORDIC gain in Q30 for a given number of stages.
    function automatic xy_t inv_gain_q30(int n);
        logic [63:0] p;
        logic [63:0] s;
        p = 64'd1 << 61;
        for (int i = 1; i < 64; i++) begin
            if (i < n && 2 * i < 62) begin
                p = p + (p >> (2 * i));
            end
        end
        s = isqrt64(p);
        return xy_t'(long_div(ONE_Q60 + (s >> 1), s));
    endfunction

endpackage

// ----- hw/rtl/great_circle_distance_core.sv -----
// Top level of the haversine great-circle distance core with output skid buffer.
`timescale 1ns / 1ps

// Usage: each transfer on the s_ channel carries two points (latitude and
// longitude in degrees scaled by 2^20) and yields exactly one transfer on the
// m_ channel carrying the distance between them in whole meters, rounded to
// nearest and saturated at half the circumference.
// Results leave in the order their inputs arrived. The datapath is a single
// pipeline with valid bits: input conditioning, four parallel rotation CORDICs,
// the haversine products, two square roots computed one bit at a time, the
// vectoring CORDIC, the final scaling and the output register. One pair is
// accepted every cycle unless the pipeline holds for a stalled receiver.
// A synchronous active-low reset empties the pipeline and the output side.
// When the receiver stalls, the pipeline keeps moving until a result lands in
// the skid register; s_tready then drops and the whole pipeline holds until
// the receiver takes a result. No item is lost or repeated.
module great_circle_distance_core #(
    parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // first_latitude, first_longitude, second_latitude, second_longitude.
    input  logic [gcd_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // distance_m.
    output logic [gcd_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int LON1_LSB = gcd_pkg::LAT_W;
    localparam int LAT2_LSB = LON1_LSB + gcd_pkg::LON_W;
    localparam int LON2_LSB = LAT2_LSB + gcd_pkg::LAT_W;

    gcd_pkg::lat_t first_latitude, second_latitude;
    gcd_pkg::lon_t first_longitude, second_longitude;

    logic advance;
    logic front_valid, rot_valid, hav_valid, isqrt_valid, vec_valid;

    gcd_pkg::angle_t ang     [gcd_pkg::ROT_LANES];
    gcd_pkg::xy_t    rot_cos [gcd_pkg::ROT_LANES];
    gcd_pkg::xy_t    rot_sin [gcd_pkg::ROT_LANES];
    gcd_pkg::rad_t   rad     [gcd_pkg::ISQRT_LANES];
    gcd_pkg::root_t  root    [gcd_pkg::ISQRT_LANES];
    gcd_pkg::angle_t z_vec;

    logic [32:0]     z_clamped;
    logic            t1_valid_reg;
    logic [56:0]     prod_reg;
    logic [57:0]     rounded;
    gcd_pkg::dist_t  dist_next;

    logic            m_tvalid_reg;
    gcd_pkg::dist_t  out_data_reg;
    logic            skid_valid_reg;
    gcd_pkg::dist_t  skid_data_reg;
    logic            pipe_fire;

    assign first_latitude   = s_tdata[LON1_LSB-1:0];
    assign first_longitude  = s_tdata[LAT2_LSB-1:LON1_LSB];
    assign second_latitude  = s_tdata[LON2_LSB-1:LAT2_LSB];
    assign second_longitude = s_tdata[LON2_LSB+gcd_pkg::LON_W-1:LON2_LSB];

    assign advance  = !skid_valid_reg;
    assign s_tready = advance;

    gcd_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ce               (advance),
        .in_valid         (s_tvalid),
        .first_latitude   (first_latitude),
        .first_longitude  (first_longitude),
        .second_latitude  (second_latitude),
        .second_longitude (second_longitude),
        .out_valid        (front_valid),
        .ang              (ang)
    );

    gcd_rot #(
        .STAGES (CORDIC_STAGES)
    ) u_rot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (advance),
        .in_valid  (front_valid),
        .ang       (ang),
        .out_valid (rot_valid),
        .cos_out   (rot_cos),
        .sin_out   (rot_sin)
    );

    gcd_hav u_hav (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (advance),
        .in_valid  (rot_valid),
        .sin_dlat  (rot_sin[gcd_pkg::LANE_DLAT]),
        .sin_dlon  (rot_sin[gcd_pkg::LANE_DLON]),
        .cos_lat1  (rot_cos[gcd_pkg::LANE_LAT1]),
        .cos_lat2  (rot_cos[gcd_pkg::LANE_LAT2]),
        .out_valid (hav_valid),
        .rad       (rad)
    );

    gcd_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (advance),
        .in_valid  (hav_valid),
        .rad       (rad),
        .out_valid (isqrt_valid),
        .root      (root)
    );

    gcd_vec #(
        .STAGES (CORDIC_STAGES)
    ) u_vec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (advance),
        .in_valid  (isqrt_valid),
        .x_in      (root[gcd_pkg::LANE_B]),
        .y_in      (root[gcd_pkg::LANE_A]),
        .out_valid (vec_valid),
        .z_out     (z_vec)
    );

    always_comb begin
        z_clamped = (z_vec < 0) ? '0 : z_vec[32:0];
        rounded   = 58'(prod_reg) + 58'd2147483648;
        if (rounded[57:32] > 26'(gcd_pkg::DIST_MAX)) begin
            dist_next = gcd_pkg::DIST_MAX;
        end else begin
            dist_next = rounded[56:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_valid_reg <= 1'b0;
        end else if (advance) begin
            t1_valid_reg <= vec_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= 57'(z_clamped * gcd_pkg::EARTH_DIAM_M);
        end
    end

    assign pipe_fire = advance && t1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (pipe_fire) begin
            if (!m_tvalid_reg || m_tready) begin
                m_tvalid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (pipe_fire) begin
            if (!m_tvalid_reg || m_tready) begin
                out_data_reg <= dist_next;
            end else begin
                skid_data_reg <= dist_next;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(gcd_pkg::M_TDATA_W - gcd_pkg::DIST_W){1'b0}}, out_data_reg};

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_tvalid_reg)
        else $error("skid register holds a result while the output register is empty");

    a_dist_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (out_data_reg <= gcd_pkg::DIST_MAX))
        else $error("distance above half the circumference");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_tvalid_reg && !m_tready))
        else $error("skid register filled without a stalled output");

endmodule

// ----- hw/rtl/gcd_front.sv -----
// Input conditioning: latitude saturation, longitude wrap and degree-to-radian scaling.
`timescale 1ns / 1ps

module gcd_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ce,
    input  logic            in_valid,
    input  gcd_pkg::lat_t   first_latitude,
    input  gcd_pkg::lon_t   first_longitude,
    input  gcd_pkg::lat_t   second_latitude,
    input  gcd_pkg::lon_t   second_longitude,
    output logic            out_valid,
    output gcd_pkg::angle_t ang [gcd_pkg::ROT_LANES]
);

    logic [3:0] valid_reg;

    gcd_pkg::lat_t  lat1_next, lat2_next;
    gcd_pkg::lat_t  lat1_reg, lat2_reg;
    gcd_pkg::diff_t dlon_raw_next, dlon_raw_reg;
    gcd_pkg::deg_t  dlon_next;
    gcd_pkg::deg_t  deg_reg [gcd_pkg::ROT_LANES];
    gcd_pkg::pp_t   plo_reg [gcd_pkg::ROT_LANES];
    gcd_pkg::pp_t   phi_reg [gcd_pkg::ROT_LANES];
    gcd_pkg::angle_t ang_reg [gcd_pkg::ROT_LANES];

    always_comb begin
        lat1_next = first_latitude;
        if (first_latitude > gcd_pkg::LAT_LIMIT) begin
            lat1_next = gcd_pkg::LAT_LIMIT;
        end else if (first_latitude < -gcd_pkg::LAT_LIMIT) begin
            lat1_next = -gcd_pkg::LAT_LIMIT;
        end
        lat2_next = second_latitude;
        if (second_latitude > gcd_pkg::LAT_LIMIT) begin
            lat2_next = gcd_pkg::LAT_LIMIT;
        end else if (second_latitude < -gcd_pkg::LAT_LIMIT) begin
            lat2_next = -gcd_pkg::LAT_LIMIT;
        end
        dlon_raw_next = gcd_pkg::DIFF_W'(second_longitude)
                      - gcd_pkg::DIFF_W'(first_longitude);
    end

    always_comb begin
        if (dlon_raw_reg >= gcd_pkg::HALF_TURN) begin
            dlon_next = gcd_pkg::DEG_W'(dlon_raw_reg - gcd_pkg::FULL_TURN);
        end else if (dlon_raw_reg < -gcd_pkg::HALF_TURN) begin
            dlon_next = gcd_pkg::DEG_W'(dlon_raw_reg + gcd_pkg::FULL_TURN);
        end else begin
            dlon_next = gcd_pkg::DEG_W'(dlon_raw_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            lat1_reg     <= lat1_next;
            lat2_reg     <= lat2_next;
            dlon_raw_reg <= dlon_raw_next;
            deg_reg[gcd_pkg::LANE_DLAT] <= gcd_pkg::DEG_W'(lat2_reg)
                                         - gcd_pkg::DEG_W'(lat1_reg);
            deg_reg[gcd_pkg::LANE_DLON] <= dlon_next;
            deg_reg[gcd_pkg::LANE_LAT1] <= gcd_pkg::DEG_W'(lat1_reg);
            deg_reg[gcd_pkg::LANE_LAT2] <= gcd_pkg::DEG_W'(lat2_reg);
        end
    end

    for (genvar l = 0; l < gcd_pkg::ROT_LANES; l++) begin : g_lane
        localparam int SH = (l == gcd_pkg::LANE_DLAT || l == gcd_pkg::LANE_DLON) ? 29 : 28;
        logic signed [gcd_pkg::SUM_W-1:0] full_prod;
        logic signed [gcd_pkg::SUM_W-1:0] rounded;

        always_comb begin
            full_prod = (gcd_pkg::SUM_W'(phi_reg[l]) <<< gcd_pkg::K_LO_W)
                      + gcd_pkg::SUM_W'(plo_reg[l]);
            rounded   = (full_prod + (66'sd1 <<< (SH - 1))) >>> SH;
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                plo_reg[l] <= gcd_pkg::PP_W'(deg_reg[l] * $signed({1'b0, gcd_pkg::D2R_LO}));
                phi_reg[l] <= gcd_pkg::PP_W'(deg_reg[l] * $signed({1'b0, gcd_pkg::D2R_HI}));
                ang_reg[l] <= rounded[gcd_pkg::ANG_W-1:0];
            end
        end

        assign ang[l] = ang_reg[l];
    end

    assign out_valid = valid_reg[3];

endmodule

// ----- hw/rtl/gcd_rot.sv -----
// Pipelined rotation-mode CORDIC bank giving cosine and sine for each angle lane.
`timescale 1ns / 1ps

module gcd_rot #(
    parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ce,
    input  logic            in_valid,
    input  gcd_pkg::angle_t ang [gcd_pkg::ROT_LANES],
    output logic            out_valid,
    output gcd_pkg::xy_t    cos_out [gcd_pkg::ROT_LANES],
    output gcd_pkg::xy_t    sin_out [gcd_pkg::ROT_LANES]
);

    localparam gcd_pkg::xy_t INV_GAIN = gcd_pkg::inv_gain_q30(STAGES);

    logic [STAGES-1:0] valid_reg;
    gcd_pkg::xy_t    x_reg [gcd_pkg::ROT_LANES][STAGES];
    gcd_pkg::xy_t    y_reg [gcd_pkg::ROT_LANES][STAGES];
    gcd_pkg::angle_t z_reg [gcd_pkg::ROT_LANES][STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    for (genvar l = 0; l < gcd_pkg::ROT_LANES; l++) begin : g_lane
        for (genvar i = 0; i < STAGES; i++) begin : g_stage
            localparam gcd_pkg::angle_t ATAN = gcd_pkg::atan_q32(i);
            gcd_pkg::xy_t    x_src, y_src;
            gcd_pkg::angle_t z_src;

            if (i == 0) begin : g_first
                assign x_src = INV_GAIN;
                assign y_src = '0;
                assign z_src = ang[l];
            end else begin : g_next
                assign x_src = x_reg[l][i-1];
                assign y_src = y_reg[l][i-1];
                assign z_src = z_reg[l][i-1];
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    if (z_src >= 0) begin
                        x_reg[l][i] <= x_src - (y_src >>> i);
                        y_reg[l][i] <= y_src + (x_src >>> i);
                        z_reg[l][i] <= z_src - ATAN;
                    end else begin
                        x_reg[l][i] <= x_src + (y_src >>> i);
                        y_reg[l][i] <= y_src - (x_src >>> i);
                        z_reg[l][i] <= z_src + ATAN;
                    end
                end
            end
        end

        assign cos_out[l] = x_reg[l][STAGES-1];
        assign sin_out[l] = y_reg[l][STAGES-1];
    end

    assign out_valid = valid_reg[STAGES-1];

endmodule

// ----- hw/rtl/gcd_hav.sv -----
// Haversine term a and its complement 1 - a, clamped to the unit interval, in Q60.
`timescale 1ns / 1ps

module gcd_hav (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ce,
    input  logic          in_valid,
    input  gcd_pkg::xy_t  sin_dlat,
    input  gcd_pkg::xy_t  sin_dlon,
    input  gcd_pkg::xy_t  cos_lat1,
    input  gcd_pkg::xy_t  cos_lat2,
    output logic          out_valid,
    output gcd_pkg::rad_t rad [gcd_pkg::ISQRT_LANES]
);

    logic [4:0] valid_reg;

    logic signed [63:0] sq1_reg, sq1_d_reg, sq1_dd_reg;
    logic signed [63:0] cc_reg, sq2_reg;
    logic signed [31:0] cc30_reg, ss30_reg;
    logic signed [63:0] prod_reg;
    logic signed [64:0] sum_next;
    logic [60:0]        a_next, a_reg, a_out_reg, b_reg;
    logic signed [63:0] cc_rnd, ss_rnd;

    always_comb begin
        cc_rnd   = (cc_reg + 64'sd536870912) >>> 30;
        ss_rnd   = (sq2_reg + 64'sd536870912) >>> 30;
        sum_next = 65'(sq1_dd_reg) + 65'(prod_reg);
        if (sum_next < 0) begin
            a_next = '0;
        end else if (sum_next > $signed({1'b0, gcd_pkg::ONE_Q60})) begin
            a_next = gcd_pkg::ONE_Q60[60:0];
        end else begin
            a_next = sum_next[60:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sq1_reg    <= $signed(sin_dlat[31:0]) * $signed(sin_dlat[31:0]);
            cc_reg     <= $signed(cos_lat1[31:0]) * $signed(cos_lat2[31:0]);
            sq2_reg    <= $signed(sin_dlon[31:0]) * $signed(sin_dlon[31:0]);
            cc30_reg   <= cc_rnd[31:0];
            ss30_reg   <= ss_rnd[31:0];
            sq1_d_reg  <= sq1_reg;
            prod_reg   <= cc30_reg * ss30_reg;
            sq1_dd_reg <= sq1_d_reg;
            a_reg      <= a_next;
            a_out_reg  <= a_reg;
            b_reg      <= gcd_pkg::ONE_Q60[60:0] - a_reg;
        end
    end

    assign rad[gcd_pkg::LANE_A] = gcd_pkg::RAD_W'(a_out_reg);
    assign rad[gcd_pkg::LANE_B] = gcd_pkg::RAD_W'(b_reg);
    assign out_valid = valid_reg[4];

endmodule

// ----- hw/rtl/gcd_isqrt.sv -----
// Pipelined restoring integer square root, one result bit per stage, two lanes.
`timescale 1ns / 1ps

module gcd_isqrt (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           ce,
    input  logic           in_valid,
    input  gcd_pkg::rad_t  rad  [gcd_pkg::ISQRT_LANES],
    output logic           out_valid,
    output gcd_pkg::root_t root [gcd_pkg::ISQRT_LANES]
);

    localparam int STEPS = gcd_pkg::ISQRT_STEPS;

    logic [STEPS-1:0] valid_reg;
    gcd_pkg::rad_t v_reg [gcd_pkg::ISQRT_LANES][STEPS];
    gcd_pkg::rad_t r_reg [gcd_pkg::ISQRT_LANES][STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[STEPS-2:0], in_valid};
        end
    end

    for (genvar l = 0; l < gcd_pkg::ISQRT_LANES; l++) begin : g_lane
        for (genvar k = 0; k < STEPS; k++) begin : g_step
            localparam gcd_pkg::rad_t BIT_K = gcd_pkg::rad_t'(64'd1 << (62 - 2 * k));
            gcd_pkg::rad_t v_src, r_src, trial;

            if (k == 0) begin : g_first
                assign v_src = rad[l];
                assign r_src = '0;
            end else begin : g_next
                assign v_src = v_reg[l][k-1];
                assign r_src = r_reg[l][k-1];
            end

            assign trial = r_src + BIT_K;

            always_ff @(posedge aclk) begin
                if (ce) begin
                    if (v_src >= trial) begin
                        v_reg[l][k] <= v_src - trial;
                        r_reg[l][k] <= (r_src >> 1) + BIT_K;
                    end else begin
                        v_reg[l][k] <= v_src;
                        r_reg[l][k] <= r_src >> 1;
                    end
                end
            end
        end

        assign root[l] = r_reg[l][STEPS-1][gcd_pkg::ROOT_W-1:0];
    end

    assign out_valid = valid_reg[STEPS-1];

endmodule

// ----- hw/rtl/gcd_vec.sv -----
// Pipelined vectoring-mode CORDIC returning the angle of the vector (x, y) in Q32.
`timescale 1ns / 1ps

module gcd_vec #(
    parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ce,
    input  logic            in_valid,
    input  gcd_pkg::root_t  x_in,
    input  gcd_pkg::root_t  y_in,
    output logic            out_valid,
    output gcd_pkg::angle_t z_out
);

    logic [STAGES-1:0] valid_reg;
    gcd_pkg::xy_t    x_reg [STAGES];
    gcd_pkg::xy_t    y_reg [STAGES];
    gcd_pkg::angle_t z_reg [STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam gcd_pkg::angle_t ATAN = gcd_pkg::atan_q32(i);
        gcd_pkg::xy_t    x_src, y_src;
        gcd_pkg::angle_t z_src;

        if (i == 0) begin : g_first
            assign x_src = gcd_pkg::xy_t'({2'b00, x_in});
            assign y_src = gcd_pkg::xy_t'({2'b00, y_in});
            assign z_src = '0;
        end else begin : g_next
            assign x_src = x_reg[i-1];
            assign y_src = y_reg[i-1];
            assign z_src = z_reg[i-1];
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                if (y_src >= 0) begin
                    x_reg[i] <= x_src + (y_src >>> i);
                    y_reg[i] <= y_src - (x_src >>> i);
                    z_reg[i] <= z_src + ATAN;
                end else begin
                    x_reg[i] <= x_src - (y_src >>> i);
                    y_reg[i] <= y_src + (x_src >>> i);
                    z_reg[i] <= z_src - ATAN;
                end
            end
        end
    end

    assign z_out     = z_reg[STAGES-1];
    assign out_valid = valid_reg[STAGES-1];

endmodule

// ----- test/tb_great_circle_distance_core.sv -----
// Self-checking testbench for the haversine great-circle distance core.
`timescale 1ns / 1ps

class distance_scoreboard;
    localparam int STAGES = gcd_pkg::CORDIC_STAGES_DEF;
    localparam longint unsigned PI60 = 64'h3243F6A8885A308D;
    localparam longint unsigned ONE60 = 64'd1 << 60;

    longint atan_tab[STAGES];
    longint start_x;
    longint deg_to_rad;
    gcd_pkg::dist_t pending_meters[$];
    int errors;

    function new();
        longint unsigned acc;
        longint unsigned term;
        longint unsigned gain;
        longint unsigned root;
        errors = 0;
        deg_to_rad = longint'(((PI60 / 180) + (64'd1 << 19)) >> 20);
        atan_tab[0] = longint'(((PI60 / 4) + (64'd1 << 27)) >> 28);
        gain = 64'd1 << 61;
        for (int i = 1; i < STAGES; i++) begin
            acc = 0;
            for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
                term = (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
                if (k % 2 == 1) acc = acc - term;
                else acc = acc + term;
            end
            atan_tab[i] = longint'((acc + (64'd1 << 27)) >> 28);
            if (2 * i < 62) gain = gain + (gain >> (2 * i));
        end
        root = floor_sqrt(gain);
        start_x = longint'((ONE60 + root / 2) / root);
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned probe;
        r = 0;
        probe = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (v >= r + probe) begin
                v = v - (r + probe);
                r = (r >> 1) + probe;
            end else begin
                r = r >> 1;
            end
            probe = probe >> 2;
        end
        return r;
    endfunction

    function longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function void sin_cos(longint z, output longint c, output longint s);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = start_x;
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        c = x;
        s = y;
    endfunction

    function longint arc_angle(longint x, longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_tab[i];
            end else begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        return z;
    endfunction

    function longint clamp_latitude(longint v);
        if (v > 94371840) return 94371840;
        if (v < -94371840) return -94371840;
        return v;
    endfunction

    function void note_input(gcd_pkg::lat_t la1, gcd_pkg::lon_t lo1,
                             gcd_pkg::lat_t la2, gcd_pkg::lon_t lo2);
        longint lat1, lat2, dlat, dlon, c1, c2, s1, s2, unused, hav, z;
        longint unsigned ra, rb, meters;
        lat1 = clamp_latitude(longint'(la1));
        lat2 = clamp_latitude(longint'(la2));
        dlat = lat2 - lat1;
        dlon = (longint'(lo2) - longint'(lo1)) % 377487360;
        if (dlon < -188743680) dlon += 377487360;
        if (dlon >= 188743680) dlon -= 377487360;
        sin_cos(round_shift(dlat * deg_to_rad, 29), unused, s1);
        sin_cos(round_shift(dlon * deg_to_rad, 29), unused, s2);
        sin_cos(round_shift(lat1 * deg_to_rad, 28), c1, unused);
        sin_cos(round_shift(lat2 * deg_to_rad, 28), c2, unused);
        hav = s1 * s1 + round_shift(c1 * c2, 30) * round_shift(s2 * s2, 30);
        if (hav < 0) hav = 0;
        if (hav > longint'(ONE60)) hav = longint'(ONE60);
        ra = floor_sqrt(longint'(hav));
        rb = floor_sqrt(ONE60 - longint'(hav));
        z = arc_angle(longint'(rb), longint'(ra));
        if (z < 0) z = 0;
        meters = (longint'(z) * 64'd12742000 + (64'd1 << 31)) >> 32;
        if (meters > 20015087) meters = 20015087;
        pending_meters.insert(pending_meters.size(), gcd_pkg::dist_t'(meters));
    endfunction

    function void check_result(logic [gcd_pkg::M_TDATA_W-1:0] data);
        gcd_pkg::dist_t want;
        if (pending_meters.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d", $time,
                     data[gcd_pkg::DIST_W-1:0]);
            errors++;
            return;
        end
        want = pending_meters.pop_front();
        if (data[gcd_pkg::DIST_W-1:0] !== want) begin
            $display("%0t: distance_m mismatch, expected %0d, actual %0d", $time,
                     want, data[gcd_pkg::DIST_W-1:0]);
            errors++;
        end
    endfunction
endclass

module tb_great_circle_distance_core;

    localparam int RANDOM_ITEMS = 1100;
    localparam int LAT_MAX = 94371840;
    localparam int LON_MAX = 188743680;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [gcd_pkg::S_TDATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [gcd_pkg::M_TDATA_W-1:0] m_tdata;

    distance_scoreboard board;
    bit quiet_phase;

    great_circle_distance_core dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3ms;
        $display("[great_circle_distance_core] ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            board.note_input(gcd_pkg::lat_t'(s_tdata[27:0]),
                             gcd_pkg::lon_t'(s_tdata[56:28]),
                             gcd_pkg::lat_t'(s_tdata[84:57]),
                             gcd_pkg::lon_t'(s_tdata[113:85]));
        end
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata);
        end
    end

    task automatic send_pair(int la1, int lo1, int la2, int lo2);
        int gap;
        if (!quiet_phase && $urandom_range(3) == 0) begin
            gap = $urandom_range(7, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, gcd_pkg::lon_t'(lo2), gcd_pkg::lat_t'(la2),
                    gcd_pkg::lon_t'(lo1), gcd_pkg::lat_t'(la1)};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic int pick_lat();
        return int'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
    endfunction

    function automatic int pick_lon();
        return int'($urandom_range(2 * LON_MAX)) - LON_MAX;
    endfunction

    task automatic drive_receiver();
        int n;
        int rounds;
        rounds = 0;
        forever begin
            rounds++;
            if (rounds == 60) begin
                m_tready <= 1'b0;
                n = 0;
                while (n < 400) begin
                    @(posedge aclk);
                    n++;
                end
            end else if (!quiet_phase && $urandom_range(2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(7, 1)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(12, 1)) @(posedge aclk);
            end
        end
    endtask

    initial begin
        int la, lo, kind;
        board = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        quiet_phase = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        fork
            drive_receiver();
        join_none

        // Directed corners: zero, identical points, poles, antipodes, field extremes.
        send_pair(0, 0, 0, 0);
        send_pair(12345678, -98765432, 12345678, -98765432);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(0, -LON_MAX, 0, LON_MAX - 1);
        send_pair(0, LON_MAX, 0, -LON_MAX);
        send_pair(-(1 << 27), 0, (1 << 27) - 1, 0);
        send_pair((1 << 27) - 1, -(1 << 28), -(1 << 27), (1 << 28) - 1);
        send_pair(-(1 << 27), (1 << 28) - 1, -(1 << 27), -(1 << 28));
        send_pair(LAT_MAX + 1, 0, LAT_MAX, 5);
        send_pair(0, -(1 << 28), 0, (1 << 28) - 1);
        send_pair(LAT_MAX, 123, LAT_MAX, -45678);
        send_pair(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        send_pair(1, 1, -1, -1);
        send_pair(0, 1, 0, 0);
        send_pair(-LAT_MAX, 0, -LAT_MAX, LON_MAX);
        send_pair(52428800, 10485760, -52428800, -178257920);
        send_pair(-1, -1, -1, -1);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - 150) quiet_phase = 1'b1;
            kind = $urandom_range(9);
            if (kind == 0) begin
                send_pair(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
            end else if (kind <= 2) begin
                la = pick_lat();
                lo = pick_lon();
                send_pair(la, lo, la + int'($urandom_range(2000)) - 1000,
                          lo + int'($urandom_range(2000)) - 1000);
            end else if (kind == 3) begin
                la = pick_lat();
                lo = pick_lon();
                send_pair(la, lo, -la + int'($urandom_range(4000)) - 2000,
                          lo + LON_MAX + int'($urandom_range(4000)) - 2000);
            end else begin
                send_pair(pick_lat(), pick_lon(), pick_lat(), pick_lon());
            end
        end
        s_tvalid <= 1'b0;

        while (board.pending_meters.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (board.pending_meters.size() != 0) begin
            $display("%0t: %0d results missing, expected 0 outstanding", $time,
                     board.pending_meters.size());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("[great_circle_distance_core] OK");
        end else begin
            $display("[great_circle_distance_core] ERROR");
        end
        $finish;
    end
endmodule

// ----- great_circle_distance_core.f -----
hw/rtl/gcd_pkg.sv
hw/rtl/gcd_front.sv
hw/rtl/gcd_rot.sv
hw/rtl/gcd_hav.sv
hw/rtl/gcd_isqrt.sv
hw/rtl/gcd_vec.sv
hw/rtl/great_circle_distance_core.sv
test/tb_great_circle_distance_core.sv
